/* hdl/bedr_pkg.sv */
`default_nettype none
package bedr_pkg;

  localparam int MAX_PATTERN = 256;
  localparam int MAX_RADIUS  = 15;
  localparam int BAND_DEPTH  = 2 * MAX_RADIUS + 1;
  localparam int PAT_AW      = $clog2(MAX_PATTERN);
  localparam int IDX_W       = $clog2(BAND_DEPTH);

  localparam int FUNC_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int PIDX_W   = 8;
  localparam int LEVEL_W  = 9;
  localparam int RADIUS_W = 4;
  localparam int PLEN_W   = 9;
  localparam int ENTRY_W  = 5;
  localparam int VALUE_W  = 8;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD_CHAR = 2'd0,
    FN_LOAD_ROOT = 2'd1,
    FN_STEP      = 2'd2,
    FN_UNUSED    = 2'd3
  } func_t;

  typedef enum logic {
    REG_RADIUS = 1'b0,
    REG_PLEN   = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic             pat_write;
    logic             root_load;
    logic             step_load;
    logic             issue;
    logic [IDX_W-1:0] idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic issue_ok;
    logic drained;
  } dp_status_t;

endpackage
`default_nettype wire

/* hdl/bedr_if.sv */
`default_nettype none
interface bedr_in_if;
  import bedr_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [CHAR_W-1:0]   base_char;
  logic [PIDX_W-1:0]   pattern_index;
  logic [LEVEL_W-1:0]  row_level;

  modport source (output valid, func, base_char, pattern_index, row_level, input ready);
  modport sink (input valid, func, base_char, pattern_index, row_level, output ready);
endinterface

interface bedr_out_if;
  import bedr_pkg::*;
  logic                valid;
  logic                ready;
  logic [ENTRY_W-1:0]  entry_index;
  logic [VALUE_W-1:0]  entry_value;
  logic                within_limit;
  logic                last;

  modport source (output valid, entry_index, entry_value, within_limit, last, input ready);
  modport sink (input valid, entry_index, entry_value, within_limit, last, output ready);
endinterface
`default_nettype wire

/* hdl/banded_edit_distance_row.sv */
// Banded edit-distance row engine.
// item channel: one beat per command. func selects a pattern character load
// (base_char into pattern_index), a root row load, or a step with base_char
// at row_level. Loads return nothing.
// result channel: a step returns 2*band_radius+1 beats, entry 0 first; the
// final beat has last set and within_limit telling whether any entry of the
// new row is at most band_radius.
// Timing: a step walks all 31 band slots through one compare/min unit, one
// slot per cycle while result is not stalled; the registered pattern-store
// read is addressed from the issue stage. The first result passes the state
// register, the compute stage and the result register. A stall on result
// holds the compute stage; the result register keeps its beat and the walk
// resumes when it is taken. The next item is taken once the walk ends, even
// while the final beat still waits.
// Config over APB: band_radius at 0x0, pattern_length at 0x4; write only
// while idle.
// Reset: band_radius 1, pattern_length 0, band row all zero. The pattern
// store is not cleared and must be loaded before steps read it.
`default_nettype none
module banded_edit_distance_row (
  input  wire logic                        clk,
  input  wire logic                        rst,
  bedr_in_if.sink                          item,
  bedr_out_if.source                       result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bedr_pkg::APB_AW-1:0] paddr,
  input  wire logic [bedr_pkg::APB_DW-1:0] pwdata,
  output logic      [bedr_pkg::APB_DW-1:0] prdata,
  output logic                             pready
);
  import bedr_pkg::*;

  logic [RADIUS_W-1:0] band_radius;
  logic [PLEN_W-1:0]   pattern_length;
  logic [RADIUS_W-1:0] tau;
  logic [PLEN_W-1:0]   plen;
  logic                wr_en;
  reg_idx_t            reg_sel;
  ctrl_cmd_t           cmd;
  dp_status_t          status;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      band_radius    <= RADIUS_W'(1);
      pattern_length <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_RADIUS: band_radius <= pwdata[RADIUS_W-1:0];
        REG_PLEN:   pattern_length <= pwdata[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_RADIUS: prdata = APB_DW'(band_radius);
      REG_PLEN:   prdata = APB_DW'(pattern_length);
      default:    prdata = '0;
    endcase
  end

  assign tau  = (32'(band_radius) > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS) : band_radius;
  assign plen = (32'(pattern_length) > MAX_PATTERN) ? PLEN_W'(MAX_PATTERN)
                                                    : pattern_length;

  bedr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_func  (item.func),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  bedr_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .item_char  (item.base_char),
    .item_pidx  (item.pattern_index),
    .item_level (item.row_level),
    .tau        (tau),
    .plen       (plen),
    .result     (result)
  );
endmodule
`default_nettype wire

/* hdl/bedr_ram.sv */
`default_nettype none
module bedr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

/* hdl/bedr_ctrl.sv */
`default_nettype none
module bedr_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  input  wire logic [bedr_pkg::FUNC_W-1:0] item_func,
  output logic                            item_ready,
  input  wire bedr_pkg::dp_status_t       status,
  output bedr_pkg::ctrl_cmd_t             cmd
);
  import bedr_pkg::*;

  state_t           state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic             take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    item_ready    = 1'b0;
    take          = 1'b0;
    cmd           = '0;
    cmd.idx       = cnt;
    case (state)
      ST_IDLE: begin
        item_ready = !rst;
        take       = item_valid && !rst;
        if (take) begin
          case (func_t'(item_func))
            FN_LOAD_CHAR: cmd.pat_write = 1'b1;
            FN_LOAD_ROOT: cmd.root_load = 1'b1;
            FN_STEP: begin
              cmd.step_load = 1'b1;
              cnt_next      = '0;
              state_next    = ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        // walk the full band store so the row shift line ends in order
        cmd.issue = status.issue_ok;
        if (status.issue_ok) begin
          cnt_next = cnt + 1'b1;
          if (cnt == IDX_W'(BAND_DEPTH - 1)) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (status.drained) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* hdl/bedr_dp.sv */
`default_nettype none
module bedr_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire bedr_pkg::ctrl_cmd_t          cmd,
  output bedr_pkg::dp_status_t              status,
  input  wire logic [bedr_pkg::CHAR_W-1:0]   item_char,
  input  wire logic [bedr_pkg::PIDX_W-1:0]   item_pidx,
  input  wire logic [bedr_pkg::LEVEL_W-1:0]  item_level,
  input  wire logic [bedr_pkg::RADIUS_W-1:0] tau,
  input  wire logic [bedr_pkg::PLEN_W-1:0]   plen,
  bedr_out_if.source                        result
);
  import bedr_pkg::*;

  localparam int COL_W = LEVEL_W + 2;

  logic [CHAR_W-1:0]  step_char;
  logic [LEVEL_W-1:0] step_level;
  logic [VALUE_W-1:0] row [BAND_DEPTH];

  // issue stage
  logic signed [COL_W-1:0] col;
  logic [COL_W-1:0]        col_m1;
  logic                    a_inrange, a_inband, a_lastband;
  logic [IDX_W:0]          two_tau;

  // compute stage
  logic               b_valid, b_go;
  logic [IDX_W-1:0]   b_idx;
  logic               b_inrange, b_inband, b_first, b_lastband;
  logic [VALUE_W-1:0] prev_new;
  logic               any_hit;
  logic [CHAR_W-1:0]  pat_q;
  logic [VALUE_W:0]   s_diag, s_left, s_up;
  logic [VALUE_W-1:0] v_min, v;
  logic               v_hit;

  logic out_valid;

  bedr_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_PATTERN)) u_pat (
    .clk   (clk),
    .we    (cmd.pat_write && (32'(item_pidx) < MAX_PATTERN)),
    .waddr (PAT_AW'(item_pidx)),
    .wdata (item_char),
    .re    (cmd.issue),
    .raddr (PAT_AW'(col_m1)),
    .rdata (pat_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.step_load) begin
      step_char  <= item_char;
      step_level <= item_level;
    end
  end

  always_comb begin
    two_tau    = (IDX_W + 1)'({tau, 1'b0});
    col        = $signed({2'b00, step_level}) - $signed(COL_W'(tau))
                 + $signed(COL_W'(cmd.idx));
    col_m1     = COL_W'(col) - COL_W'(1);
    a_inband   = (IDX_W + 1)'(cmd.idx) <= two_tau;
    a_lastband = (IDX_W + 1)'(cmd.idx) == two_tau;
    a_inrange  = a_inband && !col[COL_W-1] && (col != '0)
                 && (COL_W'(col) <= COL_W'(plen));
  end

  assign b_go            = b_valid && (!out_valid || result.ready);
  assign status.issue_ok = !b_valid || b_go;
  assign status.drained  = !b_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (cmd.issue) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      b_idx      <= cmd.idx;
      b_inrange  <= a_inrange;
      b_inband   <= a_inband;
      b_first    <= cmd.idx == '0;
      b_lastband <= a_lastband;
    end
  end

  // row[0] is old[i], row[1] is old[i+1] as the row shifts past
  always_comb begin
    s_diag = (VALUE_W + 1)'(row[0]) + (VALUE_W + 1)'(pat_q != step_char);
    s_left = (VALUE_W + 1)'(prev_new) + (VALUE_W + 1)'(1);
    s_up   = (VALUE_W + 1)'(row[1]) + (VALUE_W + 1)'(1);
    v_min  = s_diag[VALUE_W] ? '1 : s_diag[VALUE_W-1:0];
    if (!b_first && !s_left[VALUE_W] && (s_left[VALUE_W-1:0] < v_min)) begin
      v_min = s_left[VALUE_W-1:0];
    end
    if (!b_lastband && !s_up[VALUE_W] && (s_up[VALUE_W-1:0] < v_min)) begin
      v_min = s_up[VALUE_W-1:0];
    end
    if (!b_inband) begin
      v = '0;
    end else if (!b_inrange) begin
      v = VALUE_W'(tau) + VALUE_W'(1);
    end else begin
      v = v_min;
    end
    v_hit = b_inband && (v <= VALUE_W'(tau));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < BAND_DEPTH; k++) begin
        row[k] <= '0;
      end
    end else if (cmd.root_load) begin
      for (int k = 0; k < BAND_DEPTH; k++) begin
        if (k <= int'(tau) || k > 2 * int'(tau)) begin
          row[k] <= '0;
        end else begin
          row[k] <= VALUE_W'(k - int'(tau));
        end
      end
    end else if (b_go) begin
      for (int k = 0; k < BAND_DEPTH - 1; k++) begin
        row[k] <= row[k+1];
      end
      row[BAND_DEPTH-1] <= v;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      prev_new <= v;
      any_hit  <= (b_first ? 1'b0 : any_hit) | v_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_go && b_inband) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_inband) begin
      result.entry_index  <= ENTRY_W'(b_idx);
      result.entry_value  <= v;
      result.within_limit <= b_lastband && ((b_first ? 1'b0 : any_hit) | v_hit);
      result.last         <= b_lastband;
    end
  end

  assign result.valid = out_valid;
endmodule
`default_nettype wire

/* bench/testbench.sv */
`default_nettype none
module testbench;
  import bedr_pkg::*;

  typedef struct packed {
    logic [ENTRY_W-1:0] idx;
    logic [VALUE_W-1:0] dval;
    logic               in_limit;
    logic               fin;
  } band_entry_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  bedr_in_if  item_ch ();
  bedr_out_if result_ch ();

  banded_edit_distance_row u_dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the block's state
  logic [CHAR_W-1:0]   pat_mem [MAX_PATTERN];
  logic [VALUE_W-1:0]  band_row_q [BAND_DEPTH];
  logic [RADIUS_W-1:0] radius_q;
  logic [PLEN_W-1:0]   plen_q;

  band_entry_t       pending_entries [$];
  logic [CHAR_W-1:0] alphabet [4];
  bit                no_gaps;
  int                fail_count;
  int                items_sent;
  int                steps_sent;
  int                entries_checked;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #(12 * 800_000);
    $display("banded_edit_distance_row test failed");
    $finish;
  end

  function automatic int sat8(input int x);
    return (x > 255) ? 255 : x;
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  // Mirrors a command; a step works out the new band row and queues one entry per band slot.
  function automatic void predict_band_row(input func_t f, input logic [CHAR_W-1:0] ch,
                                           input logic [PIDX_W-1:0] pidx,
                                           input logic [LEVEL_W-1:0] lev);
    int                 tau;
    int                 span;
    int                 plen_lim;
    int                 col;
    int                 v;
    int                 t;
    bit                 hit;
    logic [VALUE_W-1:0] fresh [BAND_DEPTH];
    band_entry_t        e;
    tau      = int'(radius_q);
    span     = 2 * tau + 1;
    plen_lim = (int'(plen_q) > MAX_PATTERN) ? MAX_PATTERN : int'(plen_q);
    hit      = 1'b0;
    case (f)
      FN_LOAD_CHAR: pat_mem[pidx] = ch;
      FN_LOAD_ROOT: begin
        for (int i = 0; i < BAND_DEPTH; i++)
          band_row_q[i] = (i > tau && i < span) ? VALUE_W'(i - tau) : '0;
      end
      FN_STEP: begin
        for (int i = 0; i < BAND_DEPTH; i++) fresh[i] = '0;
        for (int i = 0; i < span; i++) begin
          col = int'(lev) - tau + i;
          v   = tau + 1;
          if (col >= 1 && col <= plen_lim) begin
            v = sat8(int'(band_row_q[i]) + ((pat_mem[col-1] != ch) ? 1 : 0));
            // edge slots have no left / above neighbor inside the band
            if (i > 0) begin
              t = sat8(int'(fresh[i-1]) + 1);
              if (t < v) v = t;
            end
            if (i + 1 < span) begin
              t = sat8(int'(band_row_q[i+1]) + 1);
              if (t < v) v = t;
            end
          end
          fresh[i] = VALUE_W'(v);
          if (v <= tau) hit = 1'b1;
        end
        for (int i = 0; i < BAND_DEPTH; i++) band_row_q[i] = fresh[i];
        for (int i = 0; i < span; i++) begin
          e.idx      = ENTRY_W'(i);
          e.dval     = fresh[i];
          e.fin      = (i + 1 == span);
          e.in_limit = e.fin && hit;
          pending_entries = {pending_entries, e};
        end
      end
      default: ;
    endcase
  endfunction

  // valid stays up after the beat is taken; settle() lowers it, the next call only when it draws a gap
  task automatic issue_command(input func_t f, input logic [CHAR_W-1:0] ch,
                               input logic [PIDX_W-1:0] pidx,
                               input logic [LEVEL_W-1:0] lev);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.func          <= f;
    item_ch.base_char     <= ch;
    item_ch.pattern_index <= pidx;
    item_ch.row_level     <= lev;
    do @(posedge clk); while (!item_ch.ready);
    predict_band_row(f, ch, pidx, lev);
    if (f != FN_UNUSED) items_sent++;
    if (f == FN_STEP) steps_sent++;
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    // a load gives no beat, so allow one full walk after the last one
    repeat (40) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input reg_idx_t r,
                            input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_AW'(4 * int'(r));
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_register(input reg_idx_t r, input int unsigned val);
    logic [APB_DW-1:0] rd;
    apb_access(1'b1, r, APB_DW'(val), rd);
    if (r == REG_RADIUS) radius_q = RADIUS_W'(val);
    else plen_q = PLEN_W'(val);
    apb_access(1'b0, r, '0, rd);
    check_field("register readback", val, rd);
  endtask

  function automatic logic [CHAR_W-1:0] pick_char();
    if ($urandom_range(0, 19) < 17) return alphabet[$urandom_range(0, 3)];
    return CHAR_W'($urandom);
  endfunction

  // result side: draws a random stall, possibly none, before every beat unless no_gaps is set
  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  always @(posedge clk) begin
    band_entry_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_entries.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual idx %0d value %0d last %0b",
                 $time, result_ch.entry_index, result_ch.entry_value, result_ch.last);
        fail_count++;
      end else begin
        want = pending_entries.pop_front();
        check_field("entry_index", 32'(want.idx), 32'(result_ch.entry_index));
        check_field("entry_value", 32'(want.dval), 32'(result_ch.entry_value));
        check_field("within_limit", 32'(want.in_limit), 32'(result_ch.within_limit));
        check_field("last", 32'(want.fin), 32'(result_ch.last));
        entries_checked++;
      end
    end
  end

  task automatic test_reset_state();
    logic [APB_DW-1:0] rd;
    apb_access(1'b0, REG_RADIUS, '0, rd);
    check_field("reset band_radius", 1, rd);
    apb_access(1'b0, REG_PLEN, '0, rd);
    check_field("reset pattern_length", 0, rd);
    // empty pattern: every column lies past the end
    issue_command(FN_STEP, 8'hA5, 8'h00, 9'd0);
    issue_command(FN_UNUSED, 8'hFF, 8'hFF, 9'h1FF);
    issue_command(FN_LOAD_ROOT, 8'h00, 8'h00, 9'd0);
    issue_command(FN_STEP, 8'h00, 8'h00, 9'h1FF);
    settle();
  endtask

  task automatic test_band_basics();
    logic [CHAR_W-1:0] seed_pat [8];
    seed_pat = '{8'h00, 8'hFF, 8'h3C, 8'h3C, 8'hC3, 8'h5A, 8'hA5, 8'h00};
    for (int i = 0; i < 8; i++) issue_command(FN_LOAD_CHAR, seed_pat[i], PIDX_W'(i), 9'd0);
    settle();
    set_register(REG_RADIUS, 1);
    set_register(REG_PLEN, 8);
    issue_command(FN_LOAD_ROOT, 8'h00, 8'h00, 9'd0);
    issue_command(FN_STEP, 8'h00, 8'h00, 9'd1);
    issue_command(FN_STEP, 8'hFF, 8'h00, 9'd2);
    issue_command(FN_STEP, 8'h11, 8'h00, 9'd3);
    issue_command(FN_STEP, 8'hC3, 8'h00, 9'd5);
    settle();
    // zero radius: single slot, diagonal term only
    set_register(REG_RADIUS, 0);
    issue_command(FN_LOAD_ROOT, 8'h00, 8'h00, 9'd0);
    issue_command(FN_STEP, 8'h00, 8'h00, 9'd1);
    issue_command(FN_STEP, 8'h00, 8'h00, 9'd2);
    settle();
    set_register(REG_RADIUS, 15);
    issue_command(FN_LOAD_ROOT, 8'h00, 8'h00, 9'd0);
    issue_command(FN_STEP, 8'h3C, 8'h00, 9'd0);
    issue_command(FN_STEP, 8'h00, 8'h00, 9'd1);
    issue_command(FN_STEP, 8'hFF, 8'h00, 9'h1FF);
    settle();
  endtask

  // Zero radius and a mismatching char add one per step until the value clamps.
  task automatic test_saturation();
    set_register(REG_RADIUS, 0);
    issue_command(FN_LOAD_ROOT, 8'h00, 8'h00, 9'd0);
    for (int i = 0; i < 258; i++) issue_command(FN_STEP, ~pat_mem[0], 8'h00, 9'd1);
    settle();
  endtask

  task automatic test_random_walks();
    int rand_start;
    int phase;
    int tau;
    int plen;
    int pick;
    int n;
    int cap;
    int lev;
    logic [CHAR_W-1:0] ch;
    rand_start = items_sent;
    phase      = 0;
    for (int i = 0; i < 4; i++) alphabet[i] = CHAR_W'($urandom);
    no_gaps = 1'b0;
    // pattern lengths stay at or below 64, so in-range columns use only this much of the store
    for (int i = 8; i < 64; i++)
      issue_command(FN_LOAD_CHAR, pick_char(), PIDX_W'(i), LEVEL_W'($urandom));
    while (items_sent - rand_start < 160) begin
      if (phase == 0) begin
        tau  = 15;
        plen = 64;
      end else if (phase == 1) begin
        tau  = 0;
        plen = 64;
      end else begin
        tau  = $urandom_range(0, 15);
        pick = $urandom_range(0, 9);
        plen = (pick == 0) ? 0 : (pick == 1) ? 64 : $urandom_range(1, 48);
      end
      settle();
      set_register(REG_RADIUS, tau);
      set_register(REG_PLEN, plen);
      for (int s = 0; s < 3; s++) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) != 0) begin
          // walk down one path from the root, mostly along the pattern
          cap = plen + tau + 1;
          if (cap > 40) cap = 40;
          if (plen == 0) cap = 6;
          n   = $urandom_range(1, cap);
          lev = 0;
          issue_command(FN_LOAD_ROOT, pick_char(), PIDX_W'($urandom), LEVEL_W'($urandom));
          for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 9);
            if (pick != 0) lev++;
            if (pick == 9) lev++;
            if (lev >= 1 && lev <= MAX_PATTERN && $urandom_range(0, 9) < 7)
              ch = pat_mem[lev-1];
            else
              ch = pick_char();
            issue_command(FN_STEP, ch, PIDX_W'($urandom), LEVEL_W'(lev));
          end
        end else begin
          n = $urandom_range(3, 8);
          for (int k = 0; k < n; k++)
            issue_command(func_t'($urandom_range(0, 3)), CHAR_W'($urandom),
                          PIDX_W'($urandom), LEVEL_W'($urandom_range(0, 511)));
        end
      end
      phase++;
    end
    no_gaps = 1'b0;
    settle();
  endtask

  initial begin
    rst                   <= 1'b1;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    item_ch.valid         <= 1'b0;
    item_ch.func          <= FN_LOAD_CHAR;
    item_ch.base_char     <= '0;
    item_ch.pattern_index <= '0;
    item_ch.row_level     <= '0;
    no_gaps         = 1'b0;
    fail_count      = 0;
    items_sent      = 0;
    steps_sent      = 0;
    entries_checked = 0;
    radius_q        = RADIUS_W'(1);
    plen_q          = '0;
    for (int i = 0; i < MAX_PATTERN; i++) pat_mem[i] = '0;
    for (int i = 0; i < BAND_DEPTH; i++) band_row_q[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_band_basics();
    test_saturation();
    test_random_walks();

    if (pending_entries.size() != 0) begin
      $display("%0t: %0d band entries expected but never seen", $time,
               pending_entries.size());
      fail_count += pending_entries.size();
    end
    $display("Sent %0d commands (%0d row steps); %0d band entries compared.",
             items_sent, steps_sent, entries_checked);
    $display("Radii 0..15, pattern lengths 0..64, clamp at 255 and off-pattern columns hit.");
    if (fail_count == 0) begin
      $display("banded_edit_distance_row test passed");
    end else begin
      $display("banded_edit_distance_row test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
hdl/bedr_pkg.sv
hdl/bedr_if.sv
hdl/bedr_ram.sv
hdl/bedr_ctrl.sv
hdl/bedr_dp.sv
hdl/banded_edit_distance_row.sv
bench/testbench.sv
